@@ src/stw_pkg.sv @@
// ----------------------------------------------------------------------------
// Stereo table waveshaper package
// Shared widths, configuration indices and the command type for the waveshaper modules.
// ----------------------------------------------------------------------------
package stw_pkg;

    localparam int CurvePoints = 200;
    localparam int AddrW       = $clog2(CurvePoints);

    localparam logic [1:0] CFG_DRY  = 2'd0;
    localparam logic [1:0] CFG_WET  = 2'd1;
    localparam logic [1:0] CFG_CLIP = 2'd2;

    // Datapath steps, issued by the controller states (the sum state issues none).
    typedef struct packed {
        logic load;      // capture frame inputs, clear peak if asked
        logic gain;      // g = x * gain, clip, peak update
        logic addr;      // segment index and fraction, issue curve reads
        logic interp;    // interpolation products
        logic shape;     // y, the shaped value
        logic mix;       // dry product, and w = y * output gain
        logic done;      // sum, shift, saturate into output register
        logic sel_right; // channel being worked on
    } t_dp_cmd;

endpackage

@@ src/stw_ctrl.sv @@
// ----------------------------------------------------------------------------
// Waveshaper controller
// Sequences the datapath through the steps of one frame, channel by channel.
// ----------------------------------------------------------------------------
module stw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_out_free,
    output logic              o_busy,
    output stw_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_GAIN   = 8'b0000_0010,
        S_ADDR   = 8'b0000_0100,
        S_INTERP = 8'b0000_1000,
        S_SHAPE  = 8'b0001_0000,
        S_MIX    = 8'b0010_0000,
        S_SUM    = 8'b0100_0000,
        S_WAIT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_right, n_right;

    always_comb begin
        n_state = r_state;
        n_right = r_right;
        o_cmd   = '0;
        o_cmd.sel_right = r_right;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_right    = 1'b0;
                    n_state    = S_GAIN;
                end
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_INTERP;
            end
            S_INTERP: begin
                o_cmd.interp = 1'b1;
                n_state      = S_SHAPE;
            end
            S_SHAPE: begin
                o_cmd.shape = 1'b1;
                n_state     = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                // The wet product settles during this step.
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (!r_right) begin
                    o_cmd.done = 1'b1;
                    n_right    = 1'b1;
                    n_state    = S_GAIN;
                end else if (i_out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_right <= 1'b0;
        end else begin
            r_state <= n_state;
            r_right <= n_right;
        end
    end

endmodule

@@ src/stw_datapath.sv @@
// ----------------------------------------------------------------------------
// Waveshaper datapath
// Curve memory, gain, interpolation, mix and peak tracking for one channel at
// a time, stepped by the controller.
// ----------------------------------------------------------------------------
module stw_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  stw_pkg::t_dp_cmd        i_cmd,
    input  logic                    i_pt_we,
    input  logic [7:0]              i_pt_index,
    input  logic signed [17:0]      i_pt_value,
    input  logic signed [23:0]      i_left,
    input  logic signed [23:0]      i_right,
    input  logic [15:0]             i_in_gain,
    input  logic [15:0]             i_out_gain,
    input  logic                    i_first,
    input  logic [12:0]             i_dry,
    input  logic [12:0]             i_wet,
    input  logic                    i_clip,
    input  logic                    i_out_take,
    output logic                    o_out_valid,
    output logic signed [23:0]      o_left,
    output logic signed [23:0]      o_right,
    output logic [23:0]             o_peak
);

    localparam int PW = stw_pkg::AddrW;
    localparam logic [PW-1:0] LastIdx = PW'(stw_pkg::CurvePoints - 1);

    logic signed [17:0] r_mem [stw_pkg::CurvePoints];
    logic signed [17:0] r_pa, r_pb;

    logic signed [23:0] r_x [2];
    logic [15:0]        r_ig, r_og;
    logic [23:0]        r_peak;
    logic signed [40:0] r_g;          // gained input, Q.20
    logic [40:0]        r_mag;
    logic [1:0]         r_seg;        // 0 first, 1 middle, 2 above range
    logic [19:0]        r_f;
    logic signed [40:0] r_ya, r_yb;
    logic signed [58:0] r_gp;
    logic signed [56:0] r_w;
    logic signed [41:0] r_y;
    logic signed [37:0] r_dm;
    logic signed [70:0] r_wm;
    logic signed [23:0] r_lo;

    logic signed [23:0] x_cur;
    logic signed [40:0] g_raw, g_cl, g_abs;
    logic [23:0]        a_sat, pk_base;
    logic [49:0]        m;
    logic [29:0]        k;
    logic [PW-1:0]      kk;
    logic [1:0]         seg_n;
    logic [PW-1:0]      rd_a, rd_b;
    logic signed [41:0] y_mid;
    logic signed [71:0] s;
    logic signed [23:0] sat;

    assign x_cur = r_x[i_cmd.sel_right];

    // Curve memory: one write port, registered reads.
    always_ff @(posedge i_clk) begin
        if (i_pt_we && (i_pt_index < 8'(stw_pkg::CurvePoints))) begin
            r_mem[i_pt_index[PW-1:0]] <= i_pt_value;
        end
    end

    always_comb begin
        g_raw = 41'(($signed(x_cur) * $signed({1'b0, r_ig})) >>> 12);
        g_cl  = g_raw;
        if (i_clip) begin
            if (g_raw > 41'sd1048576) g_cl = 41'sd1048576;
            if (g_raw < -41'sd1048576) g_cl = -41'sd1048576;
        end
        g_abs = g_cl[40] ? -g_cl : g_cl;
        a_sat = (g_abs > 41'd8388608) ? 24'd8388608 : g_abs[23:0];
        pk_base = r_peak;
        m  = 50'(r_mag) * 50'(stw_pkg::CurvePoints);
        k  = m[49:20];
        kk = k[PW-1:0];
        // Two curve reads per lookup: point zero and the last point outside
        // the table body, the two segment ends inside it.
        if (k == 30'd0) begin
            seg_n = 2'd0;
            rd_a  = '0;
            rd_b  = LastIdx;
        end else if (k < 30'(stw_pkg::CurvePoints)) begin
            seg_n = 2'd1;
            rd_a  = kk - PW'(1);
            rd_b  = kk;
        end else begin
            seg_n = 2'd2;
            rd_a  = '0;
            rd_b  = LastIdx;
        end
        y_mid = 42'((r_ya + r_yb) >>> 16);
        s   = 72'(r_dm) + 72'(r_wm);
        s   = s >>> 12;
        sat = (s > 72'sd8388607) ? 24'sh7FFFFF :
              (s < -72'sd8388608) ? 24'sh800000 : s[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x[0] <= i_left;
            r_x[1] <= i_right;
            r_ig   <= i_in_gain;
            r_og   <= i_out_gain;
        end
        if (i_cmd.gain) begin
            r_g   <= g_cl;
            r_mag <= g_abs;
        end
        if (i_cmd.addr) begin
            r_f   <= m[19:0];
            r_seg <= seg_n;
            r_pa  <= r_mem[rd_a];
            r_pb  <= r_mem[rd_b];
        end
        if (i_cmd.interp) begin
            if (r_seg == 2'd0) begin
                r_ya <= 41'($signed({1'b0, r_f}) * r_pa);
                r_yb <= '0;
            end else begin
                r_ya <= 41'($signed({1'b0, 21'd1048576 - 21'(r_f)}) * r_pa);
                r_yb <= 41'($signed({1'b0, r_f}) * r_pb);
            end
            r_gp <= 59'(r_g * r_pb);
        end
        if (i_cmd.shape) begin
            if (r_seg == 2'd2) begin
                r_y <= 42'(r_gp >>> 16);
            end else begin
                r_y <= r_g[40] ? -y_mid : y_mid;
            end
        end
        if (i_cmd.mix) begin
            r_dm <= 38'($signed({1'b0, i_dry}) * x_cur);
            r_w  <= 57'((r_y * $signed({1'b0, r_og})) >>> 12);
        end
        if (i_cmd.done && !i_cmd.sel_right) begin
            r_lo <= sat;
        end
        if (i_cmd.done && i_cmd.sel_right) begin
            o_left  <= r_lo;
            o_right <= sat;
            o_peak  <= r_peak;
        end
    end

    // Wet product is registered from w in the following step; keep it separate for timing.
    always_ff @(posedge i_clk) begin
        r_wm <= 71'($signed({1'b0, i_wet}) * r_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_first) begin
                r_peak <= '0;
            end else if (i_cmd.gain && (a_sat > pk_base)) begin
                r_peak <= a_sat;
            end
            if (i_cmd.done && i_cmd.sel_right) begin
                o_out_valid <= 1'b1;
            end else if (i_out_take) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ src/stereo_table_waveshaper.sv @@
// ----------------------------------------------------------------------------
// Stereo table waveshaper
// Loadable 200-point odd-symmetric curve with linear interpolation, gain,
// optional clipping, dry/wet mix and running peak.
// ----------------------------------------------------------------------------
// A curve-point write beat (action 0) gives no output. A frame beat (action 1)
// runs both channels in turn through a shared datapath of seven register steps
// each (gain, lookup, interpolation, shaping, mix, wet product, sum), so a
// result beat is presented once the sum step of the right channel loads the
// output register; no beat is taken until the controller is back in idle.
// The right channel's final step waits while an earlier
// result still sits in the output register; once the result is loaded the
// controller is back in idle and the next frame may be taken while that result
// waits. The curve memory's registered read port sets the pace of the lookup
// step. Peak tracking restarts on a frame with first_in_block set.
// Curve points never written read back as unknown values.
module stereo_table_waveshaper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata fields from bit 0: point_index[7:0], point_value[25:8],
    // left_in[49:26], right_in[73:50], input_gain[89:74], output_gain[105:90],
    // first_in_block[106], zero pad to 112 bits.
    input  logic [111:0] s_axis_tdata,
    // tuser: action.
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata fields from bit 0: left_out[23:0], right_out[47:24], peak_level[71:48].
    output logic [71:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    logic [12:0] r_dry, r_wet;
    logic        r_clip;
    logic        busy, acc, out_free;
    stw_pkg::t_dp_cmd cmd;
    logic signed [23:0] lo, ro;
    logic [23:0] pk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry  <= '0;
            r_wet  <= 13'd4096;
            r_clip <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == stw_pkg::CFG_DRY)  r_dry  <= i_cfg_data;
            if (i_cfg_index == stw_pkg::CFG_WET)  r_wet  <= i_cfg_data;
            if (i_cfg_index == stw_pkg::CFG_CLIP) r_clip <= i_cfg_data[0];
        end
    end

    assign s_axis_tready = !busy;
    assign acc           = s_axis_tvalid && s_axis_tready;
    // The final step may load the output register once it is empty or being taken.
    assign out_free      = !m_axis_tvalid || m_axis_tready;

    stw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (acc && s_axis_tuser),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    stw_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_pt_we     (acc && !s_axis_tuser),
        .i_pt_index  (s_axis_tdata[7:0]),
        .i_pt_value  (s_axis_tdata[25:8]),
        .i_left      (s_axis_tdata[49:26]),
        .i_right     (s_axis_tdata[73:50]),
        .i_in_gain   (s_axis_tdata[89:74]),
        .i_out_gain  (s_axis_tdata[105:90]),
        .i_first     (s_axis_tdata[106]),
        .i_dry       (r_dry),
        .i_wet       (r_wet),
        .i_clip      (r_clip),
        .i_out_take  (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_left      (lo),
        .o_right     (ro),
        .o_peak      (pk)
    );

    assign m_axis_tdata = {pk, ro, lo};

endmodule

@@ tb/sv/stereo_table_waveshaper_test.sv @@
// ----------------------------------------------------------------------------
// Stereo table waveshaper testbench
// Streams curve writes and stereo frames through the waveshaper, predicts every
// result beat in fixed point and checks the whole beat, with random stalls.
// ----------------------------------------------------------------------------
module stereo_table_waveshaper_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_FRAME = 1'b1;
    localparam int   LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [111:0] data;
        logic         act;
    } t_beat;

    typedef struct packed {
        logic [23:0] peak;
        logic [23:0] right;
        logic [23:0] left;
    } t_frame_out;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // tdata: point_index, point_value, left_in, right_in, input_gain,
    // output_gain, first_in_block, zero pad (lowest bit first).
    logic [111:0] s_axis_tdata = '0;
    // tuser: action.
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // tdata: left_out, right_out, peak_level (lowest bit first).
    logic [71:0]  m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_index = '0;
    logic [12:0]  i_cfg_data = '0;

    stereo_table_waveshaper u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the block state used for prediction.
    longint curve_tbl [stw_pkg::CurvePoints];
    longint peak_hold;
    longint dry_lvl, wet_lvl;
    bit     clip_on;

    t_beat      beat_q [$];
    t_frame_out frame_q [$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  calm = 1'b0;     // no idling in the final stretch
    int  drv_idle = 0, mon_idle = 0;

    function automatic longint fshr(longint v, int s);
        return v >>> s;   // arithmetic shift on longint floors
    endfunction

    function automatic longint sat24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // Waveshaping of one channel; updates the frame's peak.
    function automatic longint shape_channel(longint x, longint ig, longint og,
                                             ref longint pk);
        longint g, a, m, k, f, y, w;
        g = fshr(x * ig, 12);
        if (clip_on) begin
            if (g > 1048576) g = 1048576;
            if (g < -1048576) g = -1048576;
        end
        a = (g < 0) ? -g : g;
        if (a > 8388608) a = 8388608;
        if (a > pk) pk = a;
        a = (g < 0) ? -g : g;
        m = a * stw_pkg::CurvePoints;
        k = m >>> 20;
        f = m & 64'hFFFFF;
        if (k < 1) begin
            y = fshr(f * curve_tbl[0], 16);
            if (g < 0) y = -y;
        end else if (k < stw_pkg::CurvePoints) begin
            y = fshr(curve_tbl[k-1] * (1048576 - f) + curve_tbl[k] * f, 16);
            if (g < 0) y = -y;
        end else begin
            y = fshr(g * curve_tbl[stw_pkg::CurvePoints-1], 16);
        end
        w = fshr(y * og, 12);
        return sat24(fshr(dry_lvl * x + wet_lvl * w, 12));
    endfunction

    // Applies one beat to the shadow state and queues the expected frame result.
    function automatic void predict_beat(t_beat b);
        longint pk, l, r, ig, og;
        t_frame_out o;
        if (b.act == ACT_WRITE) begin
            if (b.data[7:0] < stw_pkg::CurvePoints) begin
                curve_tbl[b.data[7:0]] = longint'($signed(b.data[25:8]));
            end
            return;
        end
        l  = longint'($signed(b.data[49:26]));
        r  = longint'($signed(b.data[73:50]));
        ig = longint'(b.data[89:74]);
        og = longint'(b.data[105:90]);
        pk = b.data[106] ? 0 : peak_hold;
        o.left  = 24'(shape_channel(l, ig, og, pk));
        o.right = 24'(shape_channel(r, ig, og, pk));
        o.peak  = 24'(pk);
        peak_hold = pk;
        frame_q.push_back(o);
    endfunction

    function automatic t_beat make_write(int idx, int val);
        t_beat b;
        b.act = ACT_WRITE;
        b.data = '0;
        b.data[7:0] = 8'(idx);
        b.data[25:8] = 18'(val);
        return b;
    endfunction

    function automatic t_beat make_frame(int l, int r, int ig, int og, bit first);
        t_beat b;
        b.act = ACT_FRAME;
        b.data = '0;
        b.data[49:26] = 24'(l);
        b.data[73:50] = 24'(r);
        b.data[89:74] = 16'(ig);
        b.data[105:90] = 16'(og);
        b.data[106] = first;
        return b;
    endfunction

    // Random sample: mostly moderate, sometimes full scale or extreme.
    function automatic int rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 8388607 : -8388608;
            1, 2: return int'($urandom) >>> 8;
            default: return int'($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    function automatic int rand_gain();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 65535);
            1: return $urandom_range(0, 1) ? 0 : 65535;
            default: return $urandom_range(2048, 8192);
        endcase
    endfunction

    // Driver: presents queued beats; bursts of idling between beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (drv_idle > 0) begin
                drv_idle <= drv_idle - 1;
                s_axis_tvalid <= 1'b0;
            end else if (beat_q.size() > 0 && !i_cfg_we) begin
                t_beat b;
                b = beat_q.pop_front();
                predict_beat(b);
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= b.data;
                s_axis_tuser  <= b.act;
                if (!calm && $urandom_range(0, 7) == 0) drv_idle <= $urandom_range(1, 16);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure, checks each result beat.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_frame_out got, exp_o;
            got = m_axis_tdata;
            if (frame_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("Unexpected result beat %h", m_axis_tdata);
            end else begin
                exp_o = frame_q.pop_front();
                if (got !== exp_o) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Mismatch: left %h/%h right %h/%h peak %h/%h (exp/got)",
                                 exp_o.left, got.left, exp_o.right, got.right,
                                 exp_o.peak, got.peak);
                end
            end
        end
        if (mon_idle > 0) begin
            mon_idle <= mon_idle - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            mon_idle <= $urandom_range(1, 16);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n;
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic drain();
        while (beat_q.size() > 0 || s_axis_tvalid || frame_q.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 13'(val);
        case (idx)
            stw_pkg::CFG_DRY:  dry_lvl = val;
            stw_pkg::CFG_WET:  wet_lvl = val;
            stw_pkg::CFG_CLIP: clip_on = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int n;
        peak_hold = 0; dry_lvl = 0; wet_lvl = 4096; clip_on = 1'b0;
        foreach (curve_tbl[i]) curve_tbl[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Load the whole curve first so that no frame ever reads an unwritten point;
        // a linear ramp with the extreme values at the ends.
        for (int i = 0; i < stw_pkg::CurvePoints; i++)
            beat_q.push_back(make_write(i, (i == 0) ? -131072 :
                             (i == stw_pkg::CurvePoints-1) ? 131071 : i * 600 - 20000));
        // Out-of-range index is ignored by the block.
        beat_q.push_back(make_write(200, 12345));
        beat_q.push_back(make_write(255, -5));
        // Directed frames: zero, extremes, peak restart, gains at the limits.
        beat_q.push_back(make_frame(0, 0, 4096, 4096, 1));
        beat_q.push_back(make_frame(8388607, -8388608, 65535, 65535, 0));
        beat_q.push_back(make_frame(-8388608, 8388607, 4096, 4096, 0));
        beat_q.push_back(make_frame(1048576, -1048576, 4096, 4096, 1));
        beat_q.push_back(make_frame(5243, -5243, 4096, 0, 0));
        beat_q.push_back(make_frame(1, -1, 0, 65535, 0));
        beat_q.push_back(make_frame(524288, 1000, 8192, 4096, 1));
        drain();
        write_reg(stw_pkg::CFG_DRY, 4096);
        write_reg(stw_pkg::CFG_WET, 8191);
        write_reg(stw_pkg::CFG_CLIP, 1);
        beat_q.push_back(make_frame(8388607, -8388608, 65535, 65535, 1));
        beat_q.push_back(make_frame(1048575, -1048577, 4096, 4096, 0));
        drain();
        // Random phases with changing mix settings and occasional curve rewrites.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(stw_pkg::CFG_DRY, 0); write_reg(stw_pkg::CFG_WET, 4096);
                         write_reg(stw_pkg::CFG_CLIP, 0); end
                1: begin write_reg(stw_pkg::CFG_DRY, 8191); write_reg(stw_pkg::CFG_WET, 0); end
                2: begin write_reg(stw_pkg::CFG_DRY, 2048); write_reg(stw_pkg::CFG_WET, 2048);
                         write_reg(stw_pkg::CFG_CLIP, 1); end
                default: begin
                    write_reg(stw_pkg::CFG_DRY, $urandom_range(0, 8191));
                    write_reg(stw_pkg::CFG_WET, $urandom_range(0, 8191));
                    write_reg(stw_pkg::CFG_CLIP, $urandom_range(0, 1));
                end
            endcase
            if (ph == 5) calm = 1'b1;
            for (n = 0; n < 73; n++) begin
                if ($urandom_range(0, 5) == 0)
                    beat_q.push_back(make_write($urandom_range(0, 255),
                                     int'($urandom_range(0, 262143)) - 131072));
                else
                    beat_q.push_back(make_frame(rand_sample(), rand_sample(),
                                     rand_gain(), rand_gain(),
                                     $urandom_range(0, 9) == 0));
            end
            drain();
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
